/* src/byte_memory_load_store_mmio_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the byte memory load/store unit
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef BYTE_MEMORY_LOAD_STORE_MMIO_TOP_DEFINES_SVH
`define BYTE_MEMORY_LOAD_STORE_MMIO_TOP_DEFINES_SVH

// Condition that holds whenever the antecedent holds in the same cycle
`define BMLSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that holds in the cycle after the antecedent
`define BMLSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bmlsm_pkg.sv */
// ---------------------------------------------------------------------------
// bmlsm_pkg
// Shared constants, request record and queue status for the load/store unit.
// ---------------------------------------------------------------------------
package bmlsm_pkg;

    localparam int MAX_KIB   = 64;
    localparam int MEM_BYTES = MAX_KIB * 1024;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int ROW_DEPTH = MEM_BYTES / 4;

    localparam logic [31:0] MAX_KIB_U = 32'(MAX_KIB);
    localparam logic [32:0] MAX_LIMIT = 33'(MAX_KIB) * 33'd1024;

    localparam logic [6:0]  KIB_RESET = 7'd64;

    localparam logic [31:0] CON_IN_ADDR  = 32'h4000_0000;
    localparam logic [31:0] CON_OUT_ADDR = 32'h4000_0004;
    localparam logic [31:0] CON_ERR_ADDR = 32'h4000_0008;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [2:0] SIZE_MAX = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_LOAD_MEM,
        KIND_STORE_MEM,
        KIND_LOAD_ZERO,
        KIND_LOAD_CIN,
        KIND_CON_OUT,
        KIND_RANGE_ERR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ROW_W-1:0]   row;
        logic [1:0]         offset;
        logic [2:0]         size;
        logic               sext;
        logic [31:0]        data;
        logic               chan;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* src/bmlsm_front.sv */
// ---------------------------------------------------------------------------
// bmlsm_front
// Accepts input transactions, holds the size register and classifies each
// access (memory, console, range error) into a request for the queue.
// ---------------------------------------------------------------------------
module bmlsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // address, access_size, sign_extend,
                                         // store_data, console_in_byte, zero pad
    input  logic [0:0]        s_tuser,   // operation
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  bmlsm_pkg::q_stat_t q_stat,
    output logic              push,
    output bmlsm_pkg::req_t   push_req
);
    import bmlsm_pkg::*;

    logic [6:0]  memory_kib_reg;
    logic [6:0]  memory_kib_next;

    logic        op;
    logic [31:0] addr;
    logic [2:0]  size_raw;
    logic [2:0]  size_c;
    logic        sext;
    logic [31:0] wdata;
    logic [7:0]  cin;
    logic [32:0] end_sum;
    logic [32:0] limit;
    logic        is_con_out;

    always_comb
    begin
        memory_kib_next = cfg_we ? cfg_wdata : memory_kib_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_kib_reg <= KIB_RESET;
        end
        else
        begin
            memory_kib_reg <= memory_kib_next;
        end
    end

    assign op       = s_tuser[0];
    assign addr     = s_tdata[31:0];
    assign size_raw = s_tdata[34:32];
    assign sext     = s_tdata[35];
    assign wdata    = s_tdata[67:36];
    assign cin      = s_tdata[75:68];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        // clamp oversized accesses to a word
        size_c     = (size_raw > SIZE_MAX) ? SIZE_MAX : size_raw;
        end_sum    = {1'b0, addr} + 33'(size_c);
        limit      = (32'(memory_kib_reg) > MAX_KIB_U) ? MAX_LIMIT
                                                      : (33'(memory_kib_reg) << 10);
        is_con_out = (addr == CON_OUT_ADDR) || (addr == CON_ERR_ADDR);

        push_req.row    = addr[ADDR_W-1:2];
        push_req.offset = addr[1:0];
        push_req.size   = size_c;
        push_req.sext   = sext;
        push_req.data   = wdata;
        push_req.chan   = (addr == CON_ERR_ADDR);

        if (op == OP_LOAD && is_con_out)
        begin
            push_req.kind = KIND_LOAD_ZERO;
        end
        else if (op == OP_LOAD && addr == CON_IN_ADDR)
        begin
            push_req.kind = KIND_LOAD_CIN;
            push_req.data = {24'h000000, cin};
        end
        else if (op == OP_STORE && is_con_out)
        begin
            push_req.kind = KIND_CON_OUT;
        end
        else if (end_sum > limit)
        begin
            push_req.kind = KIND_RANGE_ERR;
        end
        else if (op == OP_LOAD)
        begin
            push_req.kind = KIND_LOAD_MEM;
        end
        else
        begin
            push_req.kind = KIND_STORE_MEM;
        end
    end

endmodule

/* src/bmlsm_queue.sv */
// ---------------------------------------------------------------------------
// bmlsm_queue
// Short request queue between the classifying front and the memory back end.
// ---------------------------------------------------------------------------
`include "byte_memory_load_store_mmio_top_defines.svh"

module bmlsm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmlsm_pkg::req_t    push_req,
    input  logic               pop,
    output bmlsm_pkg::req_t    pop_req,
    output bmlsm_pkg::q_stat_t q_stat
);
    import bmlsm_pkg::*;

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign pop_req      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    `BMLSM_ASSERT_IMP(a_no_overflow, push, count_reg != QCNT_W'(QUEUE_DEPTH),
        "queue written while full")
    `BMLSM_ASSERT_IMP(a_no_underflow, pop, count_reg != '0, "queue read while empty")
    `BMLSM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue occupancy lost a transaction")

endmodule

/* src/bmlsm_back.sv */
// ---------------------------------------------------------------------------
// bmlsm_back
// Carries out queued requests on four byte-lane memory banks and formats
// the result transaction in an output register.
// ---------------------------------------------------------------------------
`include "byte_memory_load_store_mmio_top_defines.svh"

module bmlsm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            pop,
    input  bmlsm_pkg::req_t req,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,   // load_data, console_out_byte
    output logic [2:0]      m_tuser    // range_error, console_out_valid, console_channel
);
    import bmlsm_pkg::*;

    logic              out_adv;
    logic              b_fire;
    logic              b_free;
    logic              issue;

    logic              b_valid_reg;
    logic              b_valid_next;
    req_t              b_req_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [39:0]       out_data_reg;
    logic [39:0]       out_data_next;
    logic [2:0]        out_user_reg;
    logic [2:0]        out_user_next;

    logic [3:0][7:0]   lane_rd;
    logic [31:0]       assembled;
    logic [31:0]       load_word;
    logic [1:0]        lane_sel;

    assign out_adv = !out_valid_reg || m_tready;
    assign b_fire  = b_valid_reg && out_adv;
    assign b_free  = !b_valid_reg || out_adv;
    assign issue   = q_valid && b_free;
    assign pop     = issue;

    // one bank per byte lane; a misaligned access wraps into the next row
    for (genvar j = 0; j < 4; j++)
    begin : lane_g
        logic [7:0]       mem [ROW_DEPTH];
        logic [7:0]       rd_reg;
        logic [1:0]       byte_idx;
        logic             active;
        logic [ROW_W-1:0] row;
        logic             we;
        logic             re;
        logic [7:0]       wbyte;

        always_comb
        begin
            byte_idx = 2'(j) - req.offset;
            active   = ({1'b0, byte_idx} < req.size);
            row      = (2'(j) < req.offset) ? req.row + 1'b1 : req.row;
            we       = issue && (req.kind == KIND_STORE_MEM) && active;
            re       = issue && (req.kind == KIND_LOAD_MEM);
            wbyte    = req.data[{byte_idx, 3'b000} +: 8];
        end

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[row] <= wbyte;
            end
            if (re)
            begin
                rd_reg <= mem[row];
            end
        end

        assign lane_rd[j] = rd_reg;
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (issue)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // reorder lanes back to little-endian byte order
    always_comb
    begin
        assembled = '0;
        lane_sel  = '0;
        for (int i = 0; i < 4; i++)
        begin
            lane_sel = 2'(i) + b_req_reg.offset;
            if (3'(i) < b_req_reg.size)
            begin
                assembled[8*i +: 8] = lane_rd[lane_sel];
            end
        end

        load_word = assembled;
        if (b_req_reg.sext)
        begin
            case (b_req_reg.size)
                3'd1:    load_word = {{24{assembled[7]}}, assembled[7:0]};
                3'd2:    load_word = {{16{assembled[15]}}, assembled[15:0]};
                3'd3:    load_word = {{8{assembled[23]}}, assembled[23:0]};
                default: load_word = assembled;
            endcase
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_user_next = '0;
        case (b_req_reg.kind)
            KIND_LOAD_MEM:
            begin
                out_data_next[31:0] = load_word;
            end
            KIND_LOAD_CIN:
            begin
                out_data_next[31:0] = {24'h000000, b_req_reg.data[7:0]};
            end
            KIND_CON_OUT:
            begin
                out_data_next[39:32] = b_req_reg.data[7:0];
                out_user_next[1]     = 1'b1;
                out_user_next[2]     = b_req_reg.chan;
            end
            KIND_RANGE_ERR:
            begin
                out_user_next[0] = 1'b1;
            end
            default:
            begin
                out_data_next = '0;
                out_user_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_req_reg <= req;
        end
        if (b_fire)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `BMLSM_ASSERT_IMP(a_err_clean, out_valid_reg && out_user_reg[0],
        out_data_reg == '0 && !out_user_reg[1], "range error result carries data")
    `BMLSM_ASSERT_NEXT(a_stage_hold, b_valid_reg && !out_adv, b_valid_reg,
        "pending result dropped under back-pressure")
    `BMLSM_ASSERT_IMP(a_issue_room, issue, !b_valid_reg || b_fire,
        "request issued over a pending result")

endmodule

/* src/byte_memory_load_store_mmio_top.sv */
// ---------------------------------------------------------------------------
// byte_memory_load_store_mmio_top
// Little-endian byte memory with memory-mapped console, one access per
// transaction.
//
//   Channel   Direction  Handshake             Contents
//   s_*       in         s_tvalid / s_tready   one load or store request
//   m_*       out        m_tvalid / m_tready   one result per request
//   cfg_*     in         cfg_we                memory size in KiB
//
// One transaction per cycle sustained while m_tready holds high; each
// result passes through the queue, bank read and output register in turn.
// Memory is four byte-lane banks with one access each per cycle, so any
// aligned or misaligned access of up to four bytes takes a single issue.
// Reset clears control and sets the size to 64 KiB; memory is not cleared.
// Output back-pressure fills the queue before s_tready drops.
// ---------------------------------------------------------------------------
module byte_memory_load_store_mmio_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // address, access_size, sign_extend,
                                   // store_data, console_in_byte, zero pad
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // load_data, console_out_byte
    output logic [2:0]  m_tuser,   // range_error, console_out_valid, console_channel
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    import bmlsm_pkg::*;

    logic    push;
    logic    pop;
    req_t    push_req;
    req_t    pop_req;
    q_stat_t q_stat;

    bmlsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_req (push_req)
    );

    bmlsm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_req(push_req),
        .pop     (pop),
        .pop_req (pop_req),
        .q_stat  (q_stat)
    );

    bmlsm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_stat.empty),
        .pop     (pop),
        .req     (pop_req),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
